### rtl/lea_pkg.sv
package lea_pkg;

    localparam int ROUND_KEY_WORDS = 192;
    localparam int KEYS_PER_ROUND  = 6;
    localparam int KEY_ROWS        = ROUND_KEY_WORDS / KEYS_PER_ROUND;
    localparam int ROW_W           = $clog2(KEY_ROWS);
    localparam int ROUND_W         = $clog2(KEY_ROWS + 1);
    localparam int ROW_BITS        = 32 * KEYS_PER_ROUND;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ENC  = 2'd1;
    localparam logic [1:0] CMD_DEC  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [5:0] RC_RESET = 6'd24;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  key_index;
        logic [31:0] key_word;
        logic [31:0] block_word0;
        logic [31:0] block_word1;
        logic [31:0] block_word2;
        logic [31:0] block_word3;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_word0;
        logic [31:0] out_word1;
        logic [31:0] out_word2;
        logic [31:0] out_word3;
    } t_out_word;

    typedef logic [3:0][31:0] t_block;

    // Number of rounds for a given round-count register value, capped by
    // the size of the key store.
    function automatic logic [ROUND_W-1:0] rounds_for(input logic [5:0] rc);
        int r;
        r = 24;
        if (rc > 6'd24) r = r + 4;
        if (rc > 6'd28) r = r + 4;
        if (r > KEY_ROWS) r = KEY_ROWS;
        return ROUND_W'(r);
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic t_block enc_round(input t_block w, input logic [ROW_BITS-1:0] k);
        t_block o;
        o[0] = rol32((w[0] ^ k[0*32 +: 32]) + (w[1] ^ k[1*32 +: 32]), 9);
        o[1] = ror32((w[1] ^ k[2*32 +: 32]) + (w[2] ^ k[3*32 +: 32]), 5);
        o[2] = ror32((w[2] ^ k[4*32 +: 32]) + (w[3] ^ k[5*32 +: 32]), 3);
        o[3] = w[0];
        return o;
    endfunction

    function automatic t_block dec_round(input t_block w, input logic [ROW_BITS-1:0] k);
        t_block o;
        o[0] = w[3];
        o[1] = (ror32(w[0], 9) - (o[0] ^ k[0*32 +: 32])) ^ k[1*32 +: 32];
        o[2] = (rol32(w[1], 5) - (o[1] ^ k[2*32 +: 32])) ^ k[3*32 +: 32];
        o[3] = (rol32(w[2], 3) - (o[2] ^ k[4*32 +: 32])) ^ k[5*32 +: 32];
        return o;
    endfunction

endpackage

### rtl/lea_block_cipher_ecb.sv
// LEA block cipher, one 128-bit block per command, ECB mode.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one word per
// command: a load writes one 32-bit round-key word into the key store if its
// index is below 192, an encrypt or decrypt carries a four-word block, and
// command 3 is taken and ignored. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns one word per encrypt or decrypt. The round count
// register is written through i_cfg_we and i_cfg_data; the user must write it
// only while the block is idle, which the block itself leaves unchecked. The
// register selects 24, 28 or 32 rounds. A load leaves the block idle and
// ready. The key store is read one row of six key words per cycle and one
// round is applied per cycle, save that the last round can wait for the
// output register, so the store's single read port paces the block.
// The next command is accepted right after the result is loaded into the
// output register, even while that result still waits to be taken. If the
// receiver stalls and the output register is still full at the last round,
// the block holds that round until the register frees.
// Reset clears the control state and sets the round count to 24. The key
// store is not cleared; every key word must be loaded before it is used.
module lea_block_cipher_ecb (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lea_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lea_pkg::t_out_word  o_out_data,
    input  logic                i_cfg_we,
    input  logic [5:0]          i_cfg_data
);
    import lea_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    // Key store: one row holds the six key words of one round.
    logic [ROW_BITS-1:0] r_mem [KEY_ROWS];
    logic [ROW_BITS-1:0] r_rd_data;

    logic                r_state, n_state;
    logic [5:0]          r_round_count;
    logic [ROW_W-1:0]    r_addr, n_addr;
    logic [ROW_W-1:0]    r_left, n_left;
    logic                r_dec, n_dec;
    t_block              r_blk, n_blk;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out, n_out;

    logic                in_fire;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [2:0]          wr_lane;
    logic [15:0]         idx_prod;
    logic [7:0]          row_x6;
    logic [7:0]          lane_full;
    logic [ROUND_W-1:0]  rounds;
    t_block              in_blk;
    t_block              rnd_out;
    logic                out_free;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign rounds   = rounds_for(r_round_count);
    assign in_blk   = {i_in_data.block_word3, i_in_data.block_word2,
                       i_in_data.block_word1, i_in_data.block_word0};

    // Split the key index into row and lane: index / 6 through a reciprocal
    // multiply that is exact over the store's range.
    assign idx_prod  = {8'd0, i_in_data.key_index} * 16'd171;
    assign wr_row    = idx_prod[10 +: ROW_W];
    assign row_x6    = ({3'd0, wr_row} << 2) + ({3'd0, wr_row} << 1);
    assign lane_full = i_in_data.key_index - row_x6;
    assign wr_lane   = lane_full[2:0];
    assign wr_en     = in_fire && (i_in_data.command == CMD_LOAD)
                       && (i_in_data.key_index < 8'(ROUND_KEY_WORDS));

    assign rnd_out = r_dec ? dec_round(r_blk, r_rd_data) : enc_round(r_blk, r_rd_data);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_left      = r_left;
        n_dec       = r_dec;
        n_blk       = r_blk;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_data.command)
                        CMD_ENC, CMD_DEC: begin
                            n_dec   = (i_in_data.command == CMD_DEC);
                            n_blk   = in_blk;
                            n_left  = ROW_W'(rounds - ROUND_W'(1));
                            rd_en   = 1'b1;
                            rd_addr = n_dec ? ROW_W'(rounds - ROUND_W'(1)) : '0;
                            n_addr  = rd_addr;
                            n_state = S_RUN;
                        end
                        CMD_LOAD, CMD_NONE: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (r_left != '0) begin
                    n_blk   = rnd_out;
                    n_left  = r_left - ROW_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_dec ? r_addr - ROW_W'(1) : r_addr + ROW_W'(1);
                    n_addr  = rd_addr;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = {rnd_out[0], rnd_out[1], rnd_out[2], rnd_out[3]};
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_row][wr_lane*32 +: 32] <= i_in_data.key_word;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_round_count <= RC_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_round_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_left <= n_left;
        r_dec  <= n_dec;
        r_blk  <= n_blk;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A block command always starts a run of rounds.
    a_block_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_data.command == CMD_ENC || i_in_data.command == CMD_DEC))
        |=> (r_state == S_RUN))
        else $error("block command did not start a run");

    // The remaining-round count only counts down within a run.
    a_left_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && $past(r_state == S_RUN)) |-> (r_left <= $past(r_left)))
        else $error("round counter rose during a run");

    // A finished block never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_left == '0 && r_out_valid && !i_out_ready)
        |=> (r_out_valid && $stable(r_out) && r_state == S_RUN))
        else $error("result register overwritten while full");
`endif

endmodule

### tb/lea_block_cipher_ecb_tb.sv
`timescale 1ns / 1ps

module lea_block_cipher_ecb_tb;
    import lea_pkg::*;

    // The longest block runs 32 rounds. The settle time after a drain covers
    // such a block with margin, so a trailing load or a stray result has had
    // time to show up before the next register write or the end.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_data;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_data;

    lea_block_cipher_ecb dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Words waiting to be sent, and the result blocks the cipher model has
    // predicted for accepted encrypt and decrypt words, oldest first.
    t_in_word    pending_words[$];
    t_out_word   expected_blocks[$];

    // The testbench's own copy of the key store and the round count register.
    logic [31:0] key_shadow [ROUND_KEY_WORDS];
    logic [5:0]  round_shadow;

    // When set, neither side inserts idle cycles.
    bit          quiet_mode;
    int          in_gap;
    int          out_stall;

    int          mismatches;
    int          cycles;
    int          n_enc;
    int          n_dec;
    int          n_loads;
    int          n_ignored;
    int          n_blocks;
    int          n_phases;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Rotations work on a doubled copy of the word so that the bits that
    // leave one end come back in at the other.
    function automatic logic [31:0] rotl_w(input logic [31:0] v, input int s);
        logic [63:0] doubled;
        doubled = {v, v};
        return doubled[(32 - s) +: 32];
    endfunction

    function automatic logic [31:0] rotr_w(input logic [31:0] v, input int s);
        return rotl_w(v, 32 - s);
    endfunction

    // Round count actually used: 24 base rounds, four more above 24 and four
    // more above 28. The store holds exactly 32 rows, so the cap never acts.
    function automatic int rounds_now();
        int nr;
        nr = 24;
        if (round_shadow > 6'd24) nr += 4;
        if (round_shadow > 6'd28) nr += 4;
        if (nr > ROUND_KEY_WORDS / KEYS_PER_ROUND) nr = ROUND_KEY_WORDS / KEYS_PER_ROUND;
        return nr;
    endfunction

    // Runs the whole cipher on one block with the current shadow keys.
    // Encryption walks rows upward; decryption undoes them from the top down.
    function automatic t_out_word lea_transform(input t_in_word it);
        logic [31:0] a, b, c, d, na, nb, nc, nd;
        int          nr;
        int          row;
        int          k;
        t_out_word   res;
        a  = it.block_word0;
        b  = it.block_word1;
        c  = it.block_word2;
        d  = it.block_word3;
        nr = rounds_now();
        if (it.command == CMD_ENC) begin
            for (row = 0; row < nr; row++) begin
                k  = row * KEYS_PER_ROUND;
                na = rotl_w((a ^ key_shadow[k]) + (b ^ key_shadow[k + 1]), 9);
                nb = rotr_w((b ^ key_shadow[k + 2]) + (c ^ key_shadow[k + 3]), 5);
                nc = rotr_w((c ^ key_shadow[k + 4]) + (d ^ key_shadow[k + 5]), 3);
                nd = a;
                {a, b, c, d} = {na, nb, nc, nd};
            end
        end else begin
            for (row = nr - 1; row >= 0; row--) begin
                k  = row * KEYS_PER_ROUND;
                na = d;
                nb = (rotr_w(a, 9) - (na ^ key_shadow[k])) ^ key_shadow[k + 1];
                nc = (rotl_w(b, 5) - (nb ^ key_shadow[k + 2])) ^ key_shadow[k + 3];
                nd = (rotl_w(c, 3) - (nc ^ key_shadow[k + 4])) ^ key_shadow[k + 5];
                {a, b, c, d} = {na, nb, nc, nd};
            end
        end
        res.out_word0 = a;
        res.out_word1 = b;
        res.out_word2 = c;
        res.out_word3 = d;
        return res;
    endfunction

    // Applies one accepted word to the shadow state, or queues its result.
    task automatic take_command(input t_in_word it);
        case (it.command)
            CMD_LOAD: begin
                if (it.key_index < ROUND_KEY_WORDS) begin
                    key_shadow[it.key_index] = it.key_word;
                    n_loads++;
                end else begin
                    n_ignored++;
                end
            end
            CMD_ENC: begin
                expected_blocks.push_back(lea_transform(it));
                n_enc++;
            end
            CMD_DEC: begin
                expected_blocks.push_back(lea_transform(it));
                n_dec++;
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 10) $display("ERROR at cycle %0d: %s", cycles, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) report($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    task automatic check_block(input t_out_word got);
        t_out_word want;
        if (expected_blocks.size() == 0) begin
            report($sformatf("result block %h with nothing expected", got));
            return;
        end
        want = expected_blocks.pop_front();
        n_blocks++;
        compare_field("out_word0", want.out_word0, got.out_word0);
        compare_field("out_word1", want.out_word1, got.out_word1);
        compare_field("out_word2", want.out_word2, got.out_word2);
        compare_field("out_word3", want.out_word3, got.out_word3);
    endtask

    // Driver: valid goes up only when the previous word is gone, and stays
    // up with the same payload until the block takes it. Each branch makes
    // exactly one assignment to the valid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) take_command(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (!quiet_mode && pending_words.size() != 0 &&
                             $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(0, 4);
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    i_in_data  <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every taken result word and stalls the output side in
    // short random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_block(o_out_data);
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // A hang anywhere ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d blocks still expected",
                     cycles, expected_blocks.size());
            $display("** lea_block_cipher_ecb: FAILED **");
            $finish;
        end
    end

    function automatic t_in_word make_word(input logic [1:0] cmd, input logic [7:0] idx,
                                           input logic [31:0] kw, input logic [127:0] blk);
        t_in_word w;
        w.command     = cmd;
        w.key_index   = idx;
        w.key_word    = kw;
        w.block_word0 = blk[127:96];
        w.block_word1 = blk[95:64];
        w.block_word2 = blk[63:32];
        w.block_word3 = blk[31:0];
        return w;
    endfunction

    function automatic logic [31:0] rand_block_word();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly blocks to encrypt and decrypt, with key reloads sprinkled in so
    // the keys keep changing under later blocks, plus some loads past the
    // store and some unused commands that the block should swallow.
    function automatic t_in_word rand_word();
        t_in_word w;
        int       pick;
        w = make_word(CMD_NONE, 8'($urandom_range(0, 255)), $urandom,
                      {rand_block_word(), rand_block_word(),
                       rand_block_word(), rand_block_word()});
        pick = $urandom_range(0, 99);
        if (pick < 36) begin
            w.command = CMD_ENC;
        end else if (pick < 72) begin
            w.command = CMD_DEC;
        end else if (pick < 87) begin
            w.command   = CMD_LOAD;
            w.key_index = 8'($urandom_range(0, ROUND_KEY_WORDS - 1));
        end else if (pick < 94) begin
            w.command   = CMD_LOAD;
            w.key_index = 8'($urandom_range(ROUND_KEY_WORDS, 255));
        end
        return w;
    endfunction

    // Waits until every queued word has been taken and every expected block
    // has come back, then lets the block settle.
    task automatic drain();
        while (pending_words.size() != 0 || i_in_valid) @(negedge i_clk);
        while (expected_blocks.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // The register is only written here, after a drain, so nothing is in
    // flight when the round count changes.
    task automatic write_round_count(input logic [5:0] value);
        @(posedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_data   <= value;
        round_shadow  = value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [5:0] rc);
        t_in_word w;
        int       counted;
        write_round_count(rc);
        n_phases++;
        // Each setting encrypts the all-zero and decrypts the all-one block.
        pending_words.push_back(make_word(CMD_ENC, 8'h00, 32'h0, {128{1'b0}}));
        pending_words.push_back(make_word(CMD_DEC, 8'hFF, 32'hFFFF_FFFF, {128{1'b1}}));
        counted = 2;
        while (counted < PHASE_WORDS) begin
            w = rand_word();
            pending_words.push_back(w);
            if (w.command != CMD_NONE &&
                !(w.command == CMD_LOAD && w.key_index >= ROUND_KEY_WORDS)) counted++;
        end
        drain();
    endtask

    initial begin
        logic [5:0] rc_list [8];
        int         i;
        int         p;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        round_shadow = RC_RESET;
        quiet_mode   = 1'b0;
        in_gap       = 0;
        out_stall    = 0;
        mismatches   = 0;
        cycles       = 0;
        for (i = 0; i < ROUND_KEY_WORDS; i++) key_shadow[i] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The key store powers up with unknown contents, so every key word is
        // loaded before the first block is sent.
        for (i = 0; i < ROUND_KEY_WORDS; i++) begin
            pending_words.push_back(make_word(CMD_LOAD, 8'(i), $urandom, {4{$urandom}}));
        end

        // Directed words at the reset round count: extreme blocks both ways,
        // the first and last key positions with extreme values, loads past
        // the end of the store, and the unused command.
        pending_words.push_back(make_word(CMD_ENC, 8'h00, 32'h0, {128{1'b0}}));
        pending_words.push_back(make_word(CMD_ENC, 8'hFF, 32'hFFFF_FFFF, {128{1'b1}}));
        pending_words.push_back(make_word(CMD_DEC, 8'h00, 32'h0, {128{1'b0}}));
        pending_words.push_back(make_word(CMD_DEC, 8'hFF, 32'hFFFF_FFFF, {128{1'b1}}));
        pending_words.push_back(make_word(CMD_ENC, 8'h00, 32'h0, {4{32'hAAAA_AAAA}}));
        pending_words.push_back(make_word(CMD_DEC, 8'h00, 32'h0, {4{32'h5555_5555}}));
        pending_words.push_back(make_word(CMD_LOAD, 8'(ROUND_KEY_WORDS), 32'hFFFF_FFFF,
                                          {128{1'b1}}));
        pending_words.push_back(make_word(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, {128{1'b1}}));
        pending_words.push_back(make_word(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, {128{1'b1}}));
        pending_words.push_back(make_word(CMD_LOAD, 8'd0, 32'h0, {128{1'b0}}));
        pending_words.push_back(make_word(CMD_LOAD, 8'(ROUND_KEY_WORDS - 1), 32'hFFFF_FFFF,
                                          {128{1'b0}}));
        pending_words.push_back(make_word(CMD_LOAD, 8'd128, 32'h8000_0001, {128{1'b0}}));
        pending_words.push_back(make_word(CMD_ENC, 8'h00, 32'h0,
                                          {32'h1, 32'h0, 32'h0, 32'h0}));
        pending_words.push_back(make_word(CMD_DEC, 8'h00, 32'h0,
                                          {32'h0, 32'h0, 32'h0, 32'h8000_0000}));
        pending_words.push_back(make_word(CMD_LOAD, 8'd0, 32'hFFFF_FFFF, {128{1'b0}}));
        pending_words.push_back(make_word(CMD_ENC, 8'h00, 32'h0, {4{$urandom}}));
        pending_words.push_back(make_word(CMD_DEC, 8'h00, 32'h0, {4{$urandom}}));
        drain();

        // Round count settings: both extremes of the register, each side of
        // both thresholds, a random value, and the reset value last with no
        // idling on either side.
        rc_list[0] = 6'd0;
        rc_list[1] = 6'd63;
        rc_list[2] = 6'd25;
        rc_list[3] = 6'd28;
        rc_list[4] = 6'd29;
        rc_list[5] = 6'd32;
        rc_list[6] = 6'($urandom_range(0, 63));
        rc_list[7] = RC_RESET;
        for (p = 0; p < 8; p++) begin
            if (p == 7) quiet_mode = 1'b1;
            run_phase(rc_list[p]);
        end

        $display("Covered %0d encrypts, %0d decrypts, %0d key loads, %0d ignored words",
                 n_enc, n_dec, n_loads, n_ignored);
        $display("over %0d round count settings; %0d result blocks checked, %0d mismatches",
                 n_phases, n_blocks, mismatches);
        if (mismatches == 0 && expected_blocks.size() == 0) begin
            $display("** lea_block_cipher_ecb: PASSED **");
        end else begin
            $display("** lea_block_cipher_ecb: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/lea_pkg.sv
rtl/lea_block_cipher_ecb.sv
tb/lea_block_cipher_ecb_tb.sv
